// ----- src/tccw_pkg.sv -----
// Shared constants, codes and types for the text console character writer.
package tccw_pkg;

	localparam int ROWS   = 25;
	localparam int COLS   = 80;
	localparam int CELLS  = ROWS * COLS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [7:0] CH_BACKSPACE = 8'h0E;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	localparam logic [1:0] FUNC_PUT  = 2'd0;
	localparam logic [1:0] FUNC_SET  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [1:0] REG_DEFAULT_ATTR = 2'd0;
	localparam logic [1:0] REG_PROMPT_COL   = 2'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_ZERO
	} state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
	endfunction

endpackage

// ----- src/text_console_char_writer_top.sv -----
// Text console character writer: cell store, cursor, scroll engine and handshakes.
//
// The block keeps a ROWS x COLS store of 16-bit cells (attribute in 15:8, character in 7:0)
// in one synchronous RAM and a row/column cursor. One result is returned per input item. Put,
// set-cursor and no-op items load the result register when taken, unless the put scrolls; a
// read first waits for the registered RAM read. A put that runs past the last row scrolls
// the store: rows are copied up through the single read and write port, then the bottom row
// is cleared. After reset a clearing pass writes zero to every cell, one per cycle; no items
// are taken during it, but configuration writes are. The output is a register, so a new item
// is taken while the previous result is being transferred.
module text_console_char_writer_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             func,
	input  logic [7:0]             char_code,
	input  logic [7:0]             attribute,
	input  logic [4:0]             row,
	input  logic [6:0]             col,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [4:0]             cursor_row,
	output logic [6:0]             cursor_col,
	output logic                   scrolled,
	output logic [7:0]             read_char,
	output logic [7:0]             read_attr,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data
);
	import tccw_pkg::*;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   ptr_q, ptr_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [7:0]          default_attr_q;
	logic [6:0]          prompt_col_q;

	logic [15:0]         cell_q [CELLS];
	logic [15:0]         rdata_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [15:0]         mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;

	logic                cp_we_s1;
	logic [ADDR_W-1:0]   cp_addr_s1;

	logic                out_valid_q;
	logic [4:0]          out_row_q;
	logic [6:0]          out_col_q;
	logic                out_scrolled_q;
	logic [7:0]          out_char_q;
	logic [7:0]          out_attr_q;

	logic                out_load;
	logic [4:0]          nxt_row_out;
	logic [6:0]          nxt_col_out;
	logic                nxt_scrolled;
	logic [7:0]          nxt_char;
	logic [7:0]          nxt_attr;

	logic                accept;
	logic [7:0]          attr_eff;
	logic [ROW_W-1:0]    row_sat;
	logic [COL_W-1:0]    col_sat;
	logic [COL_W-1:0]    bs_col;

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign attr_eff = (attribute == 8'd0) ? default_attr_q : attribute;
	assign row_sat  = (int'(row) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(row);
	assign col_sat  = (int'(col) > COLS - 1) ? COL_W'(COLS - 1) : COL_W'(col);
	assign bs_col   = (7'(col_q) > prompt_col_q) ? col_q - COL_W'(1) : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		row_d        = row_q;
		col_d        = col_q;
		mem_we       = 1'b0;
		mem_waddr    = cp_addr_s1;
		mem_wdata    = rdata_q;
		mem_raddr    = ptr_q;
		out_load     = 1'b0;
		nxt_row_out  = 5'(row_q);
		nxt_col_out  = 7'(col_q);
		nxt_scrolled = 1'b0;
		nxt_char     = 8'd0;
		nxt_attr     = 8'd0;

		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = 16'd0;
				if (ptr_q == ADDR_W'(CELLS - 1)) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				mem_raddr = cell_addr(row_sat, col_sat);
				if (accept) begin
					case (func)
						FUNC_PUT: begin
							if (char_code == CH_BACKSPACE) begin
								mem_we    = 1'b1;
								mem_waddr = cell_addr(row_q, bs_col);
								mem_wdata = {attr_eff, CH_SPACE};
								col_d     = bs_col;
								out_load  = 1'b1;
							end else if (char_code == CH_NEWLINE) begin
								col_d = '0;
								if (row_q == ROW_W'(ROWS - 1)) begin
									ptr_d   = ADDR_W'(COLS);
									state_d = ST_COPY;
								end else begin
									row_d    = row_q + ROW_W'(1);
									out_load = 1'b1;
								end
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cell_addr(row_q, col_q);
								mem_wdata = {attr_eff, char_code};
								if (col_q == COL_W'(COLS - 1)) begin
									col_d = '0;
									if (row_q == ROW_W'(ROWS - 1)) begin
										ptr_d   = ADDR_W'(COLS);
										state_d = ST_COPY;
									end else begin
										row_d    = row_q + ROW_W'(1);
										out_load = 1'b1;
									end
								end else begin
									col_d    = col_q + COL_W'(1);
									out_load = 1'b1;
								end
							end
							nxt_row_out = 5'(row_d);
							nxt_col_out = 7'(col_d);
						end
						FUNC_SET: begin
							row_d       = row_sat;
							col_d       = col_sat;
							out_load    = 1'b1;
							nxt_row_out = 5'(row_sat);
							nxt_col_out = 7'(col_sat);
						end
						FUNC_READ: begin
							state_d = ST_READ;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				out_load = 1'b1;
				nxt_char = rdata_q[7:0];
				nxt_attr = rdata_q[15:8];
				state_d  = ST_IDLE;
			end
			ST_COPY: begin
				// read row r while the cell read last cycle lands one row up
				mem_we = cp_we_s1;
				if (ptr_q == ADDR_W'(CELLS - 1)) begin
					ptr_d   = ADDR_W'((ROWS - 1) * COLS);
					state_d = ST_ZERO;
				end else begin
					ptr_d = ptr_q + ADDR_W'(1);
				end
			end
			ST_ZERO: begin
				mem_we = 1'b1;
				if (!cp_we_s1) begin
					// last copy transfer drained, now clear the bottom row
					mem_waddr = ptr_q;
					mem_wdata = 16'd0;
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						ptr_d        = '0;
						out_load     = 1'b1;
						nxt_scrolled = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						ptr_d = ptr_q + ADDR_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_we_s1 <= 1'b0;
		end else begin
			cp_we_s1 <= (state_q == ST_COPY);
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q - ADDR_W'(COLS);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= cell_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= 8'd15;
			prompt_col_q   <= 7'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEFAULT_ATTR: default_attr_q <= cfg_data;
				REG_PROMPT_COL:   prompt_col_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q      <= nxt_row_out;
			out_col_q      <= nxt_col_out;
			out_scrolled_q <= nxt_scrolled;
			out_char_q     <= nxt_char;
			out_attr_q     <= nxt_attr;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;
	assign scrolled   = out_scrolled_q;
	assign read_char  = out_char_q;
	assign read_attr  = out_attr_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !out_load)
		else $error("result register overwritten while a transfer is pending");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) <= ROWS - 1 && int'(col_q) <= COLS - 1)
		else $error("cursor outside the screen");

	a_copy_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY && cp_we_s1 |-> int'(cp_addr_s1) + COLS + 1 == int'(ptr_q))
		else $error("scroll copy write out of step with its read");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && nxt_scrolled |-> row_q == ROW_W'(ROWS - 1))
		else $error("scroll result with cursor off the bottom row");

endmodule
